@@ rtl/glmf_pkg.sv @@
// Shared types and constants for the grid local maximum finder.
// Holds field widths, register indexes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package glmf_pkg;

  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_PIXEL_BITS = 16;

  // Fixed port field widths
  localparam int PIX_W      = 16;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 4;
  localparam int COUNT_W    = 15;
  localparam int NROWS_W    = 11;
  localparam int NCOLS_W    = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int ROW_LIMIT      = 1024;
  localparam int RESET_NUM_ROWS = 10;
  localparam int RESET_NUM_COLS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_EVAL
  } ctrl_state_t;

  // Which neighbor pair the store read ports fetch
  typedef enum logic [1:0] {
    PH_CENTER,
    PH_SIDES,
    PH_BELOW
  } rd_phase_t;

  typedef struct packed {
    logic      accept;
    rd_phase_t phase;
    logic      cap_center;
    logic      cap_sides;
    logic      emit;
    logic      go_flush;
    logic      next_col;
    logic      advance;
  } dp_cmd_t;

  typedef struct packed {
    logic has_above;   // incoming pixel has a row above it to judge
    logic final_pix;   // incoming pixel is the last of the frame
    logic flush_last;  // judged column is the last column
    logic out_free;    // output register can take a result
    logic em_flush;    // judging the final row
    logic at_origin;   // position and count back at frame start
  } dp_status_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    logic [1:0] r;
    r = (s == 2'd2) ? 2'd0 : s + 2'd1;
    return r;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    logic [1:0] r;
    r = (s == 2'd0) ? 2'd2 : s - 2'd1;
    return r;
  endfunction

endpackage

@@ rtl/glmf_if.sv @@
// Channel interfaces: pixel input, result output and configuration write.
// Depends on glmf_pkg for field widths.
interface glmf_pix_if import glmf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface glmf_res_if import glmf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] value;
  logic [ROW_W-1:0]        row_index;
  logic [COL_W-1:0]        col_index;
  logic                    is_max;
  logic [COUNT_W-1:0]      maxima_count;
  logic                    last;

  modport source (output valid, output value, output row_index, output col_index,
                  output is_max, output maxima_count, output last, input ready);
  modport sink   (input valid, input value, input row_index, input col_index,
                  input is_max, input maxima_count, input last, output ready);
endinterface

interface glmf_cfg_if import glmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/grid_local_maximum_finder.sv @@
// Grid local maximum finder (4-neighbor), top level. Uses glmf_pkg, glmf_if.
// A pixel in the first row leaves the block idle and ready; a pixel below it
// has the cell above it judged: three read phases on the two-port row store,
// then the compare. The final pixel then flushes each column of the last row.
// Each compare step waits while the output register holds an untaken result.
// Reset: sync, active high; rows and cols go to 10, position and count to 0.
module grid_local_maximum_finder import glmf_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic          clk,
  input  logic          rst,
  glmf_cfg_if.sink      cfg,
  glmf_pix_if.sink      pixels,
  glmf_res_if.source    results
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  assign cfg.ready    = 1'b1;
  assign pixels.ready = in_ready;

  glmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  glmf_dp #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_pixel     (pixels.pixel),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .value        (results.value),
    .row_index    (results.row_index),
    .col_index    (results.col_index),
    .is_max       (results.is_max),
    .maxima_count (results.maxima_count),
    .last         (results.last)
  );

  // A result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!results.valid || results.ready))
    else $error("result loaded over a pending transaction");

  // A first-row pixel needs no judging, so the block is ready right away
  a_quick_ready: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready && !st.has_above && !st.final_pix) |=> pixels.ready)
    else $error("not ready after a first-row pixel");

  // After the final cell of a frame, position and count restart
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.em_flush && st.flush_last) |=> st.at_origin)
    else $error("frame did not restart after last cell");

endmodule

@@ rtl/glmf_ctrl.sv @@
// Controller for the local maximum finder: sequences pixel accept, the three
// store read phases per judged cell, and the last-row flush. Uses glmf_pkg.
module glmf_ctrl import glmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t st,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (st.has_above || st.final_pix)) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_RD_C;
      ST_RD_C: state_next = ST_EVAL;
      ST_EVAL: begin
        if (st.out_free) begin
          if (!st.em_flush) begin
            state_next = st.final_pix ? ST_RD_A : ST_IDLE;
          end else begin
            state_next = st.flush_last ? ST_IDLE : ST_RD_A;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.phase = PH_CENTER;
    in_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_RD_A: cmd.phase = PH_CENTER;
      ST_RD_B: begin
        cmd.phase      = PH_SIDES;
        cmd.cap_center = 1'b1;
      end
      ST_RD_C: begin
        cmd.phase     = PH_BELOW;
        cmd.cap_sides = 1'b1;
      end
      ST_EVAL: begin
        // hold the below address so its read data stays put while stalled
        cmd.phase = PH_BELOW;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (!st.em_flush) begin
            cmd.go_flush = st.final_pix;
            cmd.advance  = !st.final_pix;
          end else begin
            cmd.next_col = !st.flush_last;
            cmd.advance  = st.flush_last;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/glmf_dp.sv @@
// Datapath for the local maximum finder: config registers, frame position,
// three-row ring store, neighbor compare and output register. Uses glmf_pkg.
module glmf_dp import glmf_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              st,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [PIX_W-1:0] in_pixel,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [PIX_W-1:0] value,
  output logic [ROW_W-1:0]        row_index,
  output logic [COL_W-1:0]        col_index,
  output logic                    is_max,
  output logic [COUNT_W-1:0]      maxima_count,
  output logic                    last
);

  localparam int CIW    = $clog2(MAX_COLS);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int DEPTH  = 3 * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(MAX_COLS);
  localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * MAX_COLS);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] s,
                                                input logic [CIW-1:0] c);
    logic [ADDR_W-1:0] base;
    case (s)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
    return base + ADDR_W'(c);
  endfunction

  // Configuration
  logic [NROWS_W-1:0] num_rows;
  logic [NCOLS_W-1:0] num_cols;
  logic [NROWS_W-1:0] rows;
  logic [CW-1:0]      cols;
  logic [ROW_W-1:0]   last_row;

  // Frame position
  logic [ROW_W-1:0]   cur_row;
  logic [CIW-1:0]     cur_col;
  logic [1:0]         cur_slot;
  logic [COUNT_W-1:0] found;

  // Judged cell
  logic               em_flush;
  logic [CIW-1:0]     em_col;

  // Store and read data
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]     raddr0, raddr1, waddr;
  logic [PIXEL_BITS-1:0] rdata0, rdata1;
  logic signed [PIXEL_BITS-1:0] center_v, up_v, left_v, right_v, down_v;

  logic               cfg_hit;
  logic               oor;
  logic [ROW_W-1:0]   pos_row;
  logic [CIW-1:0]     pos_col;
  logic [1:0]         pos_slot;
  logic [COUNT_W-1:0] pos_found;
  logic               pos_col_end;
  logic               has_above, final_pix;
  logic [ROW_W-1:0]   adv_row;
  logic [CIW-1:0]     adv_col;
  logic [1:0]         adv_slot;

  logic [ROW_W-1:0]   em_row;
  logic [1:0]         em_slot, up_slot;
  logic [CIW-1:0]     left_col, right_col;
  logic               has_up, has_down, has_left, has_right;
  logic               cell_max;
  logic [COUNT_W-1:0] found_next;
  logic               flush_last;

  // Clamp registers to their legal ranges
  always_comb begin
    if (num_rows == '0) begin
      rows = NROWS_W'(1);
    end else if (num_rows > NROWS_W'(ROW_LIMIT)) begin
      rows = NROWS_W'(ROW_LIMIT);
    end else begin
      rows = num_rows;
    end
    if (num_cols == '0) begin
      cols = CW'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(num_cols);
    end
  end

  assign last_row = ROW_W'(rows - NROWS_W'(1));

  // Position of the incoming pixel; restarts if somehow past the frame
  assign oor         = (NROWS_W'(cur_row) >= rows) || (CW'(cur_col) >= cols);
  assign pos_row     = oor ? '0 : cur_row;
  assign pos_col     = oor ? '0 : cur_col;
  assign pos_slot    = oor ? 2'd0 : cur_slot;
  assign pos_found   = oor ? '0 : found;
  assign pos_col_end = (CW'(pos_col) + CW'(1)) == cols;
  assign has_above   = pos_row != '0;
  assign final_pix   = (pos_row == last_row) && pos_col_end;

  always_comb begin
    if (final_pix) begin
      adv_row  = '0;
      adv_col  = '0;
      adv_slot = 2'd0;
    end else if (!pos_col_end) begin
      adv_row  = pos_row;
      adv_col  = pos_col + CIW'(1);
      adv_slot = pos_slot;
    end else begin
      adv_row  = pos_row + ROW_W'(1);
      adv_col  = '0;
      adv_slot = slot_inc(pos_slot);
    end
  end

  // Judged cell and its neighbors
  assign em_row    = em_flush ? cur_row : cur_row - ROW_W'(1);
  assign em_slot   = em_flush ? cur_slot : slot_dec(cur_slot);
  assign up_slot   = slot_dec(em_slot);
  assign has_up    = em_row != '0;
  assign has_down  = !em_flush;
  assign has_left  = em_col != '0;
  assign has_right = (CW'(em_col) + CW'(1)) < cols;
  assign flush_last = !has_right;
  assign left_col  = has_left ? em_col - CIW'(1) : em_col;
  assign right_col = has_right ? em_col + CIW'(1) : em_col;

  always_comb begin
    case (cmd.phase)
      PH_CENTER: begin
        raddr0 = addr_of(em_slot, em_col);
        raddr1 = addr_of(up_slot, em_col);
      end
      PH_SIDES: begin
        raddr0 = addr_of(em_slot, left_col);
        raddr1 = addr_of(em_slot, right_col);
      end
      PH_BELOW: begin
        raddr0 = addr_of(cur_slot, em_col);
        raddr1 = addr_of(cur_slot, em_col);
      end
      default: begin
        raddr0 = '0;
        raddr1 = '0;
      end
    endcase
  end

  assign waddr = addr_of(pos_slot, pos_col);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[waddr] <= PIXEL_BITS'($unsigned(in_pixel));
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_center) begin
      center_v <= rdata0;
      up_v     <= rdata1;
    end
    if (cmd.cap_sides) begin
      left_v  <= rdata0;
      right_v <= rdata1;
    end
  end

  assign down_v = rdata0;

  assign cell_max = !(has_up && (up_v > center_v)) &&
                    !(has_down && (down_v > center_v)) &&
                    !(has_left && (left_v > center_v)) &&
                    !(has_right && (right_v > center_v));
  assign found_next = found + COUNT_W'(cell_max);

  assign cfg_hit = cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NROWS_W'(RESET_NUM_ROWS);
      num_cols <= NCOLS_W'(RESET_NUM_COLS);
      cur_row  <= '0;
      cur_col  <= '0;
      cur_slot <= 2'd0;
      found    <= '0;
      em_flush <= 1'b0;
      em_col   <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows <= cfg_data[NROWS_W-1:0];
      end else begin
        num_cols <= cfg_data[NCOLS_W-1:0];
      end
      cur_row  <= '0;
      cur_col  <= '0;
      cur_slot <= 2'd0;
      found    <= '0;
    end else begin
      if (cmd.accept) begin
        found    <= pos_found;
        em_flush <= !has_above;
        em_col   <= has_above ? pos_col : '0;
        if (has_above || final_pix) begin
          cur_row  <= pos_row;
          cur_col  <= pos_col;
          cur_slot <= pos_slot;
        end else begin
          cur_row  <= adv_row;
          cur_col  <= adv_col;
          cur_slot <= adv_slot;
        end
      end
      if (cmd.emit) begin
        found <= found_next;
      end
      if (cmd.go_flush) begin
        em_flush <= 1'b1;
        em_col   <= '0;
      end
      if (cmd.next_col) begin
        em_col <= em_col + CIW'(1);
      end
      if (cmd.advance) begin
        cur_row  <= adv_row;
        cur_col  <= adv_col;
        cur_slot <= adv_slot;
        if (final_pix) begin
          found <= '0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value        <= PIX_W'($unsigned(center_v));
      row_index    <= em_row;
      col_index    <= COL_W'(em_col);
      is_max       <= cell_max;
      maxima_count <= found_next;
      last         <= em_flush && flush_last;
    end
  end

  always_comb begin
    st.has_above  = has_above;
    st.final_pix  = final_pix;
    st.flush_last = flush_last;
    st.out_free   = !out_valid || out_ready;
    st.em_flush   = em_flush;
    st.at_origin  = (cur_row == '0) && (cur_col == '0) && (found == '0);
  end

endmodule

@@ test/grid_local_maximum_finder_tb.sv @@
`timescale 1ns / 100ps
// Testbench for grid_local_maximum_finder: streams grids through the pixel channel,
// predicts every judged cell and checks each result transaction against it.
// Depends on glmf_pkg and the channel interfaces in glmf_if.
module grid_local_maximum_finder_tb;
  import glmf_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 330;
  localparam int MAX_IDLE      = 18;

  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    is_max;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } cell_result_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [PIX_W-1:0] pixel;
    bit                      typed;
    cell_result_t            want;
  } step_t;

  logic clk = 1'b0;
  logic rst;

  glmf_pix_if pix ();
  glmf_res_if res ();
  glmf_cfg_if cfg ();

  grid_local_maximum_finder u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixels  (pix),
    .results (res)
  );

  always #1 clk = ~clk;

  // Grid model: three-row ring of values plus frame position and count
  logic signed [PIX_W-1:0] grid [3][DEF_MAX_COLS];
  logic [NROWS_W-1:0]      rows_cfg = NROWS_W'(RESET_NUM_ROWS);
  logic [NCOLS_W-1:0]      cols_cfg = NCOLS_W'(RESET_NUM_COLS);
  int                      at_row = 0;
  int                      at_col = 0;
  logic [COUNT_W-1:0]      maxima_so_far = '0;
  cell_result_t            pending_cells [$];

  int  mismatches = 0;
  int  pixels_sent = 0;
  int  cells_checked = 0;
  int  writes_done = 0;
  int  frames_seen = 0;
  bit  pix_quiet = 1'b0;
  bit  res_quiet = 1'b0;

  task automatic report(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  function automatic int rows_in_use();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > ROW_LIMIT) return ROW_LIMIT;
    return int'(rows_cfg);
  endfunction

  function automatic int cols_in_use();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return int'(cols_cfg);
  endfunction

  function automatic cell_result_t mk_cell(input logic signed [PIX_W-1:0] v, input int r,
                                           input int c, input bit m, input int n, input bit l);
    cell_result_t x;
    x.value  = v;
    x.row    = ROW_W'(r);
    x.col    = COL_W'(c);
    x.is_max = m;
    x.count  = COUNT_W'(n);
    x.last   = l;
    return x;
  endfunction

  function automatic void judge_cell(input int r, input int c, input int rows, input int cols,
                                     input bit fin);
    logic signed [PIX_W-1:0] v;
    bit top;
    v = grid[r % 3][c];
    top = 1'b1;
    if (r > 0 && grid[(r - 1) % 3][c] > v) top = 1'b0;
    if (r + 1 < rows && grid[(r + 1) % 3][c] > v) top = 1'b0;
    if (c > 0 && grid[r % 3][c - 1] > v) top = 1'b0;
    if (c + 1 < cols && grid[r % 3][c + 1] > v) top = 1'b0;
    if (top) maxima_so_far++;
    pending_cells.push_back(mk_cell(v, r, c, top, int'(maxima_so_far), fin));
  endfunction

  function automatic void take_pixel(input logic signed [PIX_W-1:0] v, input bit typed,
                                     input cell_result_t want);
    int rows, cols, first, c;
    rows = rows_in_use();
    cols = cols_in_use();
    if (at_row >= rows || at_col >= cols) begin
      at_row = 0;
      at_col = 0;
      maxima_so_far = '0;
    end
    grid[at_row % 3][at_col] = v;
    first = pending_cells.size();
    if (at_row > 0) judge_cell(at_row - 1, at_col, rows, cols, 1'b0);
    if (at_row == rows - 1 && at_col == cols - 1) begin
      // final pixel: the whole last row goes out
      for (c = 0; c < cols; c++) judge_cell(at_row, c, rows, cols, c == cols - 1);
      at_row = 0;
      at_col = 0;
      maxima_so_far = '0;
    end else if (at_col + 1 < cols) begin
      at_col++;
    end else begin
      at_col = 0;
      at_row++;
    end
    if (typed && pending_cells.size() > first) pending_cells[first] = want;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_NUM_ROWS) begin
      rows_cfg = data[NROWS_W-1:0];
    end else if (idx == REG_NUM_COLS) begin
      cols_cfg = data[NCOLS_W-1:0];
    end else begin
      return;
    end
    at_row = 0;
    at_col = 0;
    maxima_so_far = '0;
  endfunction

  // Block must be idle before a register write
  task automatic settle();
    pix.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    apply_reg(idx, data);
    writes_done++;
  endtask

  task automatic send_pixel(input logic signed [PIX_W-1:0] v, input bit typed,
                            input cell_result_t want);
    int gap;
    gap = pix_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= v;
    do @(posedge clk); while (!pix.ready);
    take_pixel(v, typed, want);
    pixels_sent++;
  endtask

  function automatic logic signed [PIX_W-1:0] draw_pixel(input int style);
    int pick;
    case (style)
      0: begin
        return PIX_W'($urandom());
      end
      1: begin
        return PIX_W'($urandom_range(0, 4) - 2);   // narrow range, lots of ties
      end
      2: begin
        pick = $urandom_range(0, 3);
        if (pick == 0) return 16'sh8000;
        if (pick == 1) return 16'sh7FFF;
        if (pick == 2) return 16'sh0000;
        return 16'shFFFF;
      end
      default: begin
        return PIX_W'($urandom_range(0, 255) - 128);
      end
    endcase
  endfunction

  function automatic step_t px(input logic signed [PIX_W-1:0] v);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.idx   = '0;
    s.data  = '0;
    s.pixel = v;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic step_t px_want(input logic signed [PIX_W-1:0] v, input cell_result_t w);
    step_t s;
    s = px(v);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  function automatic step_t wr(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = px('0);
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  // Result ready with a random stall per transaction
  initial begin : drive_ready
    int stall;
    res.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = res_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  always @(posedge clk) begin : watch_results
    cell_result_t got;
    cell_result_t want;
    string diff;
    if (rst === 1'b0 && res.valid && res.ready) begin
      got.value  = res.value;
      got.row    = res.row_index;
      got.col    = res.col_index;
      got.is_max = res.is_max;
      got.count  = res.maxima_count;
      got.last   = res.last;
      if (got.last === 1'b1) frames_seen++;
      if (pending_cells.size() == 0) begin
        report($sformatf("unexpected result: cell (%0d,%0d) value %0d",
                         got.row, got.col, got.value));
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        diff = "";
        if (got.value !== want.value) diff = {diff, " value"};
        if (got.row !== want.row) diff = {diff, " row_index"};
        if (got.col !== want.col) diff = {diff, " col_index"};
        if (got.is_max !== want.is_max) diff = {diff, " is_max"};
        if (got.count !== want.count) diff = {diff, " maxima_count"};
        if (got.last !== want.last) diff = {diff, " last"};
        if (diff != "") begin
          report({$sformatf("wrong%s: got v=%0d (%0d,%0d) max=%0b n=%0d last=%0b",
                            diff, got.value, got.row, got.col, got.is_max, got.count,
                            got.last),
                  $sformatf(", want v=%0d (%0d,%0d) max=%0b n=%0d last=%0b",
                            want.value, want.row, want.col, want.is_max,
                            want.count, want.last)});
        end
      end
    end
  end

  initial begin : stimulus
    step_t plan [$];
    int phase, style, frame, count, i, sel, random_pixels, waited;
    logic [NROWS_W-1:0] rows_val;
    logic [NCOLS_W-1:0] cols_val;

    rst       = 1'b1;
    pix.valid = 1'b0;
    pix.pixel = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    foreach (grid[r, c]) grid[r][c] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset sizes (10x10), extremes, clamped sizes, ties, ignored index
    plan.push_back(px(16'sh7FFF));
    repeat (9) plan.push_back(px(16'sh8000));
    plan.push_back(px_want(16'sh0000, mk_cell(16'sh7FFF, 0, 0, 1'b1, 1, 1'b0)));
    plan.push_back(wr(REG_NUM_ROWS, 16'hF800));
    plan.push_back(wr(REG_NUM_COLS, 16'hFFE0));
    plan.push_back(px_want(16'sh8000, mk_cell(16'sh8000, 0, 0, 1'b1, 1, 1'b1)));
    plan.push_back(px_want(16'sh7FFF, mk_cell(16'sh7FFF, 0, 0, 1'b1, 1, 1'b1)));
    plan.push_back(wr(REG_NUM_ROWS, 16'h0002));
    plan.push_back(wr(REG_NUM_COLS, 16'hFFE2));
    plan.push_back(px(16'sd100));
    plan.push_back(px(16'sd100));
    // writes outside the register list must not restart the frame
    plan.push_back(wr(8'd2, 16'hFFFF));
    plan.push_back(wr(8'hFF, 16'h0000));
    plan.push_back(px(16'sd100));
    plan.push_back(px(16'sd100));
    plan.push_back(wr(REG_NUM_ROWS, 16'hF803));
    plan.push_back(wr(REG_NUM_COLS, 16'h0003));
    plan.push_back(px(-16'sd1));
    plan.push_back(px(16'sd5));
    plan.push_back(px(-16'sd7));
    plan.push_back(px_want(16'sd3, mk_cell(-16'sd1, 0, 0, 1'b0, 0, 1'b0)));
    plan.push_back(wr(REG_NUM_COLS, 16'h001F));

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_WRITE) begin
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_pixel(plan[k].pixel, plan[k].typed, plan[k].want);
      end
    end

    // Random phases; phase 0 is the widest grid, phase 1 the tallest one
    random_pixels = 0;
    for (phase = 0; phase < 2 || random_pixels < RANDOM_ITEMS; phase++) begin
      pix_quiet = ($urandom_range(0, 3) == 0);
      res_quiet = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 3);
      if (phase == 0) begin
        rows_val = 11'd2;
        cols_val = 5'd31;
      end else if (phase == 1) begin
        rows_val = 11'd2047;
        cols_val = 5'd1;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) rows_val = NROWS_W'($urandom_range(1, 4));
        else if (sel == 6) rows_val = '0;
        else if (sel == 7) rows_val = NROWS_W'($urandom_range(5, 8));
        else if (sel == 8) rows_val = NROWS_W'($urandom_range(0, 2047));
        else rows_val = 11'd1;
        sel = $urandom_range(0, 9);
        if (sel <= 5) cols_val = NCOLS_W'($urandom_range(1, 6));
        else if (sel == 6) cols_val = 5'd16;
        else if (sel == 7) cols_val = '0;
        else if (sel == 8) cols_val = NCOLS_W'($urandom_range(17, 31));
        else cols_val = NCOLS_W'($urandom_range(7, 15));
      end
      if (phase < 2 || $urandom_range(0, 4) != 0)
        write_reg(REG_NUM_ROWS, CFG_DATA_W'(($urandom() & 32'hF800) | rows_val));
      if (phase < 2 || $urandom_range(0, 4) != 0)
        write_reg(REG_NUM_COLS, CFG_DATA_W'(($urandom() & 32'hFFE0) | cols_val));
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom()));

      frame = rows_in_use() * cols_in_use();
      if (phase == 1) begin
        count = $urandom_range(24, 40);   // tall grid, stops well before its last row
      end else if (frame <= 40) begin
        count = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);   // cut short
      end else begin
        count = $urandom_range(1, 48);
      end
      if (phase >= 2 && count > RANDOM_ITEMS - random_pixels)
        count = RANDOM_ITEMS - random_pixels;
      for (i = 0; i < count; i++) begin
        send_pixel(draw_pixel(style), 1'b0, '0);
        random_pixels++;
      end
    end

    pix.valid <= 1'b0;
    for (waited = 0; waited < 200000 && pending_cells.size() != 0; waited++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_cells.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_cells.size()));

    $display("Sent %0d pixels and %0d register writes; checked %0d judged cells.",
             pixels_sent, writes_done, cells_checked);
    $display("Finished frames seen: %0d; mismatches: %0d.", frames_seen, mismatches);
    if (mismatches == 0) begin
      $display("grid_local_maximum_finder_tb passed");
    end else begin
      $display("grid_local_maximum_finder_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_cells.size());
    $display("grid_local_maximum_finder_tb failed");
    $finish;
  end

endmodule

@@ grid_local_maximum_finder.f @@
rtl/glmf_pkg.sv
rtl/glmf_if.sv
rtl/glmf_ctrl.sv
rtl/glmf_dp.sv
rtl/grid_local_maximum_finder.sv
test/grid_local_maximum_finder_tb.sv
